>>> hdl/smlt_pkg.sv
// Package for the station MAC learning table.
// Holds the payload structs, the table record layout and the
// controller/datapath command and status groups. No dependencies.
`default_nettype none

package smlt_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned LenW   = 16;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned MacW   = 48;
  localparam int unsigned RssiW  = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 7;

  // 802.11 type code of a data frame
  localparam logic [TypeW-1:0] DATA_FRAME_TYPE = 2'd2;
  // Minimum frame length after reset
  localparam logic [LenW-1:0]  MIN_LEN_RESET   = 16'd64;

  // One received frame
  typedef struct packed {
    logic        [LenW-1:0]   frame_length;
    logic        [TypeW-1:0]  frame_type;
    logic        [MacW-1:0]   source_mac;
    logic signed [RssiW-1:0]  signal_strength;
    logic        [StampW-1:0] timestamp;
  } in_t;

  // One lookup result
  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic             new_station;
    logic             table_full;
  } out_t;

  // One stored station record
  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [RssiW-1:0]  strength;
    logic [StampW-1:0] last_seen;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;   // capture the frame on an input transfer
    logic scan_clear;  // restart the slot scan at slot 0
    logic scan_next;   // step to the next slot
    logic wr_hit;      // refresh the matching slot, report it
    logic wr_new;      // append the station, report it as new
    logic full_out;    // report a full table, store nothing
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;      // frame too short or not a data frame
    logic at_end;    // scan index reached the occupied count
    logic mac_match; // slot read data matches the frame's MAC
    logic full;      // every slot is occupied
    logic out_free;  // result register can take a result now
  } status_t;

endpackage

`default_nettype wire

>>> hdl/smlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smlt_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 2,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/smlt_datapath.sv
// Datapath of the station MAC learning table: frame register, config
// register, occupied count, scan index, record RAM and result register.
// Depends on smlt_pkg and smlt_ram.
`default_nettype none

module smlt_datapath #(
  parameter int unsigned Entries = 128
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [smlt_pkg::LenW-1:0] cfg_data_i,
  input  wire smlt_pkg::in_t             in_data_i,
  input  wire smlt_pkg::cmd_t            cmd_i,
  output smlt_pkg::status_t              status_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output smlt_pkg::out_t                 out_data_o
);

  localparam int unsigned AddrW  = $clog2(Entries);
  localparam int unsigned CountW = $clog2(Entries + 1);

  smlt_pkg::in_t             item_q;
  logic [smlt_pkg::LenW-1:0] min_len_q;
  logic [CountW-1:0]         count_q, count_d;
  logic [CountW-1:0]         idx_q, idx_d;
  smlt_pkg::out_t            out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic            ram_we;
  logic [AddrW-1:0] ram_waddr;
  smlt_pkg::entry_t ram_wdata;
  smlt_pkg::entry_t ram_rdata;

  // Frame capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  // Minimum length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= smlt_pkg::MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  // Scan index and occupied count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_clear) begin
      idx_d = '0;
    end else if (cmd_i.scan_next) begin
      idx_d = idx_q + 1'b1;
    end
    count_d = count_q;
    if (cmd_i.wr_new) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  // Record RAM: read follows the scan index, write on hit or append
  assign ram_we              = cmd_i.wr_hit | cmd_i.wr_new;
  assign ram_waddr           = cmd_i.wr_hit ? idx_q[AddrW-1:0] : count_q[AddrW-1:0];
  assign ram_wdata.mac       = item_q.source_mac;
  assign ram_wdata.strength  = item_q.signal_strength;
  assign ram_wdata.last_seen = item_q.timestamp;

  smlt_ram #(
    .Width ($bits(smlt_pkg::entry_t)),
    .Depth (Entries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result register; slot number keeps its low bits
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.wr_hit) begin
      out_d.slot_index  = smlt_pkg::SlotW'(idx_q);
      out_d.new_station = 1'b0;
      out_d.table_full  = 1'b0;
      out_valid_d       = 1'b1;
    end else if (cmd_i.wr_new) begin
      out_d.slot_index  = smlt_pkg::SlotW'(count_q);
      out_d.new_station = 1'b1;
      out_d.table_full  = 1'b0;
      out_valid_d       = 1'b1;
    end else if (cmd_i.full_out) begin
      out_d.slot_index  = '0;
      out_d.new_station = 1'b0;
      out_d.table_full  = 1'b1;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Status toward the controller
  assign status_o.drop      = (item_q.frame_length < min_len_q) ||
                              (item_q.frame_type != smlt_pkg::DATA_FRAME_TYPE);
  assign status_o.at_end    = (idx_q == count_q);
  assign status_o.mac_match = (ram_rdata.mac == item_q.source_mac);
  assign status_o.full      = (count_q == CountW'(Entries));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/smlt_ctrl.sv
// Controller of the station MAC learning table: sequences filter,
// slot scan and result for one frame at a time. Depends on smlt_pkg.
`default_nettype none

module smlt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire smlt_pkg::status_t status_i,
  output smlt_pkg::cmd_t         cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StFilter = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StComp   = 3'd3;
  localparam logic [2:0] StHit    = 3'd4;
  localparam logic [2:0] StMiss   = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StFilter;
        end
      end
      StFilter: begin
        if (status_i.drop) begin
          state_d = StIdle;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d          = StScan;
        end
      end
      // RAM read of the indexed slot is in flight here
      StScan: begin
        state_d = status_i.at_end ? StMiss : StComp;
      end
      StComp: begin
        if (status_i.mac_match) begin
          state_d = StHit;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = StScan;
        end
      end
      StHit: begin
        if (status_i.out_free) begin
          cmd_o.wr_hit = 1'b1;
          state_d      = StIdle;
        end
      end
      StMiss: begin
        if (status_i.out_free) begin
          if (status_i.full) begin
            cmd_o.full_out = 1'b1;
          end else begin
            cmd_o.wr_new = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/station_mac_learning_table_core.sv
// Top level of the station MAC learning table: controller plus datapath.
// Depends on smlt_pkg, smlt_ctrl, smlt_datapath and smlt_ram.
//
// Learns the stations heard on the air. Each input transfer is one received
// frame; frames shorter than the configured minimum length or not of data
// type give no result. Otherwise the source MAC is searched among the
// occupied slots, one slot at a time through the record RAM's registered
// read port. A hit refreshes that slot's strength and time; a miss appends
// a new slot, or reports table_full and stores nothing when all
// TABLE_ENTRIES slots are taken. One frame is in work at a time. The
// result register lets the next frame enter while a result waits. The
// minimum length register resets to 64; it is to be written only while
// idle, and the block itself does not enforce this.
`default_nettype none

module station_mac_learning_table_core #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [smlt_pkg::LenW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire smlt_pkg::in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output smlt_pkg::out_t                 out_data_o
);

  smlt_pkg::cmd_t    cmd;
  smlt_pkg::status_t status;

  smlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smlt_datapath #(
    .Entries (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/station_mac_learning_table_core_tb.sv
`timescale 1ns / 100ps
// Testbench for station_mac_learning_table_core: directed and random frame traffic.
// A local copy of the station table predicts each result. Needs smlt_pkg and the core RTL.

module station_mac_learning_table_core_tb;

  // Package items used here
  localparam int unsigned LenW   = smlt_pkg::LenW;
  localparam int unsigned TypeW  = smlt_pkg::TypeW;
  localparam int unsigned MacW   = smlt_pkg::MacW;
  localparam int unsigned RssiW  = smlt_pkg::RssiW;
  localparam int unsigned StampW = smlt_pkg::StampW;
  localparam int unsigned SlotW  = smlt_pkg::SlotW;
  localparam logic [TypeW-1:0] DATA_FRAME_TYPE = smlt_pkg::DATA_FRAME_TYPE;
  localparam logic [LenW-1:0]  MIN_LEN_RESET   = smlt_pkg::MIN_LEN_RESET;
  typedef smlt_pkg::in_t    in_t;
  typedef smlt_pkg::out_t   out_t;
  typedef smlt_pkg::entry_t entry_t;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned MAC_POOL      = 200;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES  = 3_000_000;

  // 802.11 frame type codes other than data
  localparam logic [TypeW-1:0] MGMT_FRAME_TYPE = 2'd0;
  localparam logic [TypeW-1:0] CTRL_FRAME_TYPE = 2'd1;
  localparam logic [TypeW-1:0] EXT_FRAME_TYPE  = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [LenW-1:0]  cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;

  // Predicted station table and settings
  entry_t           seen_table [TABLE_ENTRIES];
  int unsigned      seen_count;
  logic [LenW-1:0]  min_len;
  out_t             pending_results [$];
  logic [MacW-1:0]  mac_pool [MAC_POOL];

  // Traffic shaping
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  // Statistics
  int unsigned      errors;
  int unsigned      cycle_count;
  int unsigned      frames_sent;
  int unsigned      dropped_frames;
  int unsigned      results_checked;
  int unsigned      fresh_results;
  int unsigned      refresh_results;
  int unsigned      full_results;

  station_mac_learning_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk_i = ~clk_i;

  // Predict one frame: drop, refresh a known station, append, or report full
  function automatic bit learn_station(input in_t frame, output out_t result);
    int unsigned s;
    result = '0;
    if (frame.frame_length < min_len || frame.frame_type != DATA_FRAME_TYPE) begin
      dropped_frames++;
      return 1'b0;
    end
    for (s = 0; s < seen_count; s++) begin
      if (seen_table[s].mac == frame.source_mac) begin
        seen_table[s].strength  = frame.signal_strength;
        seen_table[s].last_seen = frame.timestamp;
        result.slot_index = s[SlotW-1:0];
        return 1'b1;
      end
    end
    if (seen_count >= TABLE_ENTRIES) begin
      result.table_full = 1'b1;
      return 1'b1;
    end
    seen_table[seen_count].mac       = frame.source_mac;
    seen_table[seen_count].strength  = frame.signal_strength;
    seen_table[seen_count].last_seen = frame.timestamp;
    result.slot_index  = seen_count[SlotW-1:0];
    result.new_station = 1'b1;
    seen_count++;
    return 1'b1;
  endfunction

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MacW-1:0];
  endfunction

  function automatic bit is_known(input logic [MacW-1:0] mac);
    int unsigned s;
    for (s = 0; s < seen_count; s++) begin
      if (seen_table[s].mac == mac) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_t frame_of(input logic [LenW-1:0] len, input logic [TypeW-1:0] ftype,
                                   input logic [MacW-1:0] mac, input logic [RssiW-1:0] rssi,
                                   input logic [StampW-1:0] stamp);
    in_t f;
    f.frame_length    = len;
    f.frame_type      = ftype;
    f.source_mac      = mac;
    f.signal_strength = rssi;
    f.timestamp       = stamp;
    return f;
  endfunction

  // Mostly well-formed data frames from the MAC pool; some short, some non-data
  function automatic in_t random_frame(input int unsigned pool_lim);
    in_t f;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    f.signal_strength = RssiW'($urandom_range(0, 255));
    f.timestamp       = $urandom();
    f.source_mac      = (roll % 20 == 0) ? rand_mac() : mac_pool[$urandom_range(0, pool_lim-1)];
    if (roll < 70) begin
      f.frame_type   = DATA_FRAME_TYPE;
      f.frame_length = (roll < 10) ? min_len : LenW'($urandom_range(65535, min_len));
    end else if (roll < 85) begin
      f.frame_type   = DATA_FRAME_TYPE;
      f.frame_length = (min_len == 0) ? LenW'($urandom_range(0, 65535))
                                      : LenW'($urandom_range(0, min_len - 1));
    end else begin
      f.frame_type   = TypeW'($urandom_range(0, 3));
      if (f.frame_type == DATA_FRAME_TYPE) f.frame_type = EXT_FRAME_TYPE;
      f.frame_length = LenW'($urandom_range(0, 65535));
    end
    return f;
  endfunction

  // Send one frame; called and returns at a falling edge
  task automatic send_frame(input in_t frame);
    out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (learn_station(frame, predicted)) pending_results.push_back(predicted);
    frames_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let every pending result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_min_length(input logic [LenW-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    min_len = value;
  endtask

  // Short frames and non-data frames at the reset minimum length
  task automatic test_drop_rules();
    send_frame(frame_of(16'd63, DATA_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd5));
    send_frame(frame_of(16'd0, DATA_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd6));
    send_frame(frame_of(16'hFFFF, MGMT_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd7));
    send_frame(frame_of(16'hFFFF, CTRL_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd8));
    send_frame(frame_of(16'hFFFF, EXT_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd9));
    send_frame(frame_of(16'd64, MGMT_FRAME_TYPE, 48'h0123_4567_89AB, 8'h10, 32'd10));
  endtask

  // Appends and refreshes with extreme field values
  task automatic test_learning_basics();
    send_frame(frame_of(16'd64, DATA_FRAME_TYPE, '0, 8'h80, '0));
    send_frame(frame_of(16'hFFFF, DATA_FRAME_TYPE, '1, 8'h7F, '1));
    send_frame(frame_of(16'd1518, DATA_FRAME_TYPE, '0, 8'hC4, 32'd1000));
    send_frame(frame_of(16'd1518, DATA_FRAME_TYPE, '1, 8'h00, 32'd2000));
    send_frame(frame_of(16'd100, DATA_FRAME_TYPE, 48'h5555_5555_5555, 8'hAA, 32'h5555_5555));
    send_frame(frame_of(16'd100, DATA_FRAME_TYPE, 48'hAAAA_AAAA_AAAA, 8'h55, 32'hAAAA_AAAA));
    send_frame(frame_of(16'd100, DATA_FRAME_TYPE, 48'h5555_5555_5555, 8'hFF, 32'd3));
  endtask

  // Minimum length register at both extremes
  task automatic test_min_length();
    write_min_length(16'd0);
    send_frame(frame_of(16'd0, DATA_FRAME_TYPE, 48'h0000_0000_0001, 8'h01, 32'd11));
    send_frame(frame_of(16'd1, DATA_FRAME_TYPE, 48'h0000_0000_0001, 8'h02, 32'd12));
    write_min_length(16'hFFFF);
    send_frame(frame_of(16'hFFFE, DATA_FRAME_TYPE, '1, 8'h03, 32'd13));
    send_frame(frame_of(16'hFFFF, DATA_FRAME_TYPE, '1, 8'h04, 32'd14));
    send_frame(frame_of(16'hFFFF, DATA_FRAME_TYPE, 48'h8000_0000_0000, 8'h05, 32'd15));
  endtask

  // One random phase with its own length setting, idling and MAC spread
  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input logic [LenW-1:0] length_min,
                                     input int unsigned pool_lim);
    int unsigned i;
    write_min_length(length_min);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < count; i++) send_frame(random_frame(pool_lim));
    drain_results();
  endtask

  // Fill every slot, then unknown stations must be flagged
  task automatic test_table_full();
    logic [MacW-1:0] mac;
    int unsigned     i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_min_length(MIN_LEN_RESET);
    while (seen_count < TABLE_ENTRIES) begin
      mac = rand_mac();
      if (!is_known(mac)) send_frame(frame_of(16'd200, DATA_FRAME_TYPE, mac, 8'hD0, $urandom()));
    end
    for (i = 0; i < 3; i++) begin
      mac = rand_mac();
      if (!is_known(mac)) send_frame(frame_of(16'd300, DATA_FRAME_TYPE, mac, 8'hB0, $urandom()));
    end
    send_frame(frame_of(16'd300, DATA_FRAME_TYPE, seen_table[0].mac, 8'hE0, 32'd77));
    send_frame(frame_of(16'd300, DATA_FRAME_TYPE, seen_table[TABLE_ENTRIES-1].mac, 8'hE1,
                        32'd78));
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker and run limit
  always @(posedge clk_i) begin
    out_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached, %0d results pending", $time,
               LIMIT_CYCLES, pending_results.size());
      $display("station_mac_learning_table_core_tb: errors");
      $finish;
    end else if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: slot %0d new %0b full %0b", $time,
                 out_data.slot_index, out_data.new_station, out_data.table_full);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.table_full) full_results++;
        else if (want.new_station) fresh_results++;
        else refresh_results++;
        if (out_data.slot_index != want.slot_index) begin
          errors++;
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                   out_data.slot_index);
        end
        if (out_data.new_station != want.new_station) begin
          errors++;
          $display("%0t: new_station expected %0b actual %0b", $time, want.new_station,
                   out_data.new_station);
        end
        if (out_data.table_full != want.table_full) begin
          errors++;
          $display("%0t: table_full expected %0b actual %0b", $time, want.table_full,
                   out_data.table_full);
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned j;
    bit          dup;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    seen_count     = 0;
    min_len        = MIN_LEN_RESET;
    errors         = 0;
    cycle_count    = 0;
    frames_sent    = 0;
    dropped_frames = 0;
    results_checked = 0;
    fresh_results  = 0;
    refresh_results = 0;
    full_results   = 0;

    // Distinct random station addresses for the random phases
    i = 0;
    while (i < MAC_POOL) begin
      mac_pool[i] = rand_mac();
      dup = 1'b0;
      for (j = 0; j < i; j++) if (mac_pool[j] == mac_pool[i]) dup = 1'b1;
      if (!dup) i++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_drop_rules();
    test_learning_basics();
    test_min_length();
    test_random_traffic(500, 0, 0, MIN_LEN_RESET, 40);
    test_random_traffic(500, 52, 0, 16'd0, 90);
    test_random_traffic(500, 0, 52, LenW'($urandom_range(1, 1600)), 150);
    test_random_traffic(500, 13, 13, 16'hFFFF, MAC_POOL);
    test_table_full();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d frames (%0d dropped) over min lengths 0, 64, 65535 and one random value",
             frames_sent, dropped_frames);
    $display("with idle and stall mixes; checked %0d results: %0d new, %0d refreshed, %0d full",
             results_checked, fresh_results, refresh_results, full_results);
    if (errors == 0) begin
      $display("station_mac_learning_table_core_tb: clean");
    end else begin
      $display("station_mac_learning_table_core_tb: errors");
    end
    $finish;
  end

endmodule
